// ----- hw/rtl/potential_field_avoidance_steer_assert.svh -----
// Assertion macros for the checker file.
`ifndef POTENTIAL_FIELD_AVOIDANCE_STEER_ASSERT_SVH
`define POTENTIAL_FIELD_AVOIDANCE_STEER_ASSERT_SVH

// Same-cycle implication under the block reset.
`define PFAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the block reset.
`define PFAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pfas_pkg.sv -----
package pfas_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_ANGLE, ST_DIV, ST_MOD, ST_ROT_INIT, ST_ROT,
      ST_MUL, ST_SAT, ST_VEC_INIT, ST_VEC, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      REG_STRENGTH_GAIN, REG_INFLUENCE_DISTANCE, REG_FORCE_LIMIT,
      REG_FIRST_ANGLE, REG_ANGLE_STEP, REG_SCAN_LENGTH
   } reg_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take_sample;
      logic       prep;
      logic       angle;
      logic       div_step;
      logic       mod_step;
      logic       rot_init;
      logic       rot_step;
      logic       mul;
      logic       sat;
      logic       vec_init;
      logic       vec_step;
      logic       load_out;
      logic [4:0] step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_seen;
   } status_type;

   localparam logic [4:0]  DIV_LAST    = 5'd27;
   localparam logic [4:0]  MOD_LAST    = 5'd11;
   localparam logic [4:0]  CORDIC_LAST = 5'd15;
   localparam logic [27:0] TWO_PI_Q13  = 28'd51472;
   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
   localparam logic signed [20:0] PI_Q16      = 21'sd205887;
   localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
   localparam logic signed [16:0] HALF_Q12    = 17'sd2048;

   // Arctangent of 2^-i in units of 2^-16 rad.
   function automatic logic [16:0] atan_lut(input logic [3:0] i);
      logic [16:0] v;
      case (i)
         4'd0:    v = 17'd51472;
         4'd1:    v = 17'd30385;
         4'd2:    v = 17'd16055;
         4'd3:    v = 17'd8150;
         4'd4:    v = 17'd4091;
         4'd5:    v = 17'd2047;
         4'd6:    v = 17'd1024;
         4'd7:    v = 17'd512;
         4'd8:    v = 17'd256;
         4'd9:    v = 17'd128;
         4'd10:   v = 17'd64;
         4'd11:   v = 17'd32;
         4'd12:   v = 17'd16;
         4'd13:   v = 17'd8;
         4'd14:   v = 17'd4;
         default: v = 17'd2;
      endcase
      return v;
   endfunction

   // Saturate a signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/potential_field_avoidance_steer.sv -----
// Channel   Direction  Payload
// req_      in         tdata[15:0] range_sample; tuser[0] req_type (1 = tick)
// rsp_      out        tdata: linear_velocity, turn_rate, repulse_x, repulse_y
// csr_      in         addr = register index, wdata = value
//
// Samples can be accepted every cycle while the block is idle, not during a tick.
// A tick runs the 28-step divider, the 12-step angle reduction and two 16-step
// CORDIC passes; a tick before the first scan goes straight to the result.
// Reset is synchronous and active high; no clearing pass is needed.
// A finished result waits in the output register while samples keep flowing;
// a tick finishing behind an untaken result waits for rsp_tready.
module potential_field_avoidance_steer #(
   parameter int WINDOW = 90
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] range_sample
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // linear_velocity, turn_rate, repulse_x, repulse_y
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import pfas_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic signed [15:0] linear_velocity, turn_rate, repulse_x, repulse_y;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {repulse_y, repulse_x, turn_rate, linear_velocity};

   pfas_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_is_tick (req_tuser[0]),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   pfas_dp #(.WINDOW(WINDOW)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .range_sample    (req_tdata),
      .cmd             (cmd),
      .status          (status),
      .linear_velocity (linear_velocity),
      .turn_rate       (turn_rate),
      .repulse_x       (repulse_x),
      .repulse_y       (repulse_y)
   );

endmodule

// ----- hw/rtl/pfas_ctrl.sv -----
module pfas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_is_tick,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pfas_pkg::status_type status,
   output pfas_pkg::cmd_type    cmd
);
   import pfas_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_is_tick) begin
               state_in = status.scan_seen ? ST_PREP : ST_DONE;
            end
         end
         ST_PREP:     state_in = ST_ANGLE;
         ST_ANGLE:    state_in = ST_DIV;
         ST_DIV:      if (step_ff == DIV_LAST) state_in = ST_MOD;
         ST_MOD:      if (step_ff == MOD_LAST) state_in = ST_ROT_INIT;
         ST_ROT_INIT: state_in = ST_ROT;
         ST_ROT:      if (step_ff == CORDIC_LAST) state_in = ST_MUL;
         ST_MUL:      state_in = ST_SAT;
         ST_SAT:      state_in = ST_VEC_INIT;
         ST_VEC_INIT: state_in = ST_VEC;
         ST_VEC:      if (step_ff == CORDIC_LAST) state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs to the datapath and the handshake.
   always_comb begin
      cmd             = '0;
      cmd.step        = step_ff;
      cmd.take_sample = (state_ff == ST_IDLE) && req_tvalid && !req_is_tick;
      cmd.prep        = (state_ff == ST_PREP);
      cmd.angle       = (state_ff == ST_ANGLE);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.mod_step    = (state_ff == ST_MOD);
      cmd.rot_init    = (state_ff == ST_ROT_INIT);
      cmd.rot_step    = (state_ff == ST_ROT);
      cmd.mul         = (state_ff == ST_MUL);
      cmd.sat         = (state_ff == ST_SAT);
      cmd.vec_init    = (state_ff == ST_VEC_INIT);
      cmd.vec_step    = (state_ff == ST_VEC);
      cmd.load_out    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
      req_tready      = (state_ff == ST_IDLE);
      rsp_tvalid      = rsp_valid_ff;
   end

   // Step counter restarts whenever the state changes; the result valid flag is set on load and cleared when taken.
   always_comb begin
      step_in = (state_in != state_ff) ? 5'd0 : step_ff + 5'd1;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/pfas_dp.sv -----
module pfas_dp #(
   parameter int WINDOW = 90
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [2:0]           csr_addr,
   input  logic [15:0]          csr_wdata,
   input  logic [15:0]          range_sample,
   input  pfas_pkg::cmd_type    cmd,
   output pfas_pkg::status_type status,
   output logic signed [15:0]   linear_velocity,
   output logic signed [15:0]   turn_rate,
   output logic signed [15:0]   repulse_x,
   output logic signed [15:0]   repulse_y
);
   import pfas_pkg::*;

   localparam logic [12:0] WIN = 13'(WINDOW);

   // Configuration registers.
   logic [15:0]        sg_ff, infl_ff;
   logic [14:0]        flim_ff;
   logic signed [15:0] fa_ff;
   logic [13:0]        astep_ff;
   logic [11:0]        slen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff    <= 16'd3277;
         infl_ff  <= 16'd141;
         flim_ff  <= 15'd2458;
         fa_ff    <= 16'sd0;
         astep_ff <= 14'd143;
         slen_ff  <= 12'd360;
      end else if (csr_write) begin
         case (csr_addr)
            REG_STRENGTH_GAIN:      sg_ff    <= csr_wdata;
            REG_INFLUENCE_DISTANCE: infl_ff  <= csr_wdata;
            REG_FORCE_LIMIT:        flim_ff  <= csr_wdata[14:0];
            REG_FIRST_ANGLE:        fa_ff    <= csr_wdata;
            REG_ANGLE_STEP:         astep_ff <= csr_wdata[13:0];
            REG_SCAN_LENGTH:        slen_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // Scan tracking: running window minima and the latched result of the last scan.
   logic [11:0] cnt_ff, fi_ff, ri_ff, dfi_ff, dri_ff;
   logic [15:0] fr_ff, rr_ff, dfr_ff, drr_ff;
   logic        seen_ff;
   logic [12:0] rear_start, cnt_ext;
   logic        front_hit, rear_hit, scan_end;
   logic [15:0] fr_new, rr_new;
   logic [11:0] fi_new, ri_new;

   always_comb begin
      cnt_ext    = {1'b0, cnt_ff};
      rear_start = ({1'b0, slen_ff} > WIN) ? {1'b0, slen_ff} - WIN : 13'd0;
      front_hit  = (cnt_ext < WIN) && (cnt_ff == 12'd0 || range_sample < fr_ff);
      rear_hit   = (cnt_ext >= rear_start) &&
                   (cnt_ext == rear_start || range_sample < rr_ff);
      scan_end   = (cnt_ext + 13'd1) >= {1'b0, slen_ff};
      fr_new     = front_hit ? range_sample : fr_ff;
      fi_new     = front_hit ? cnt_ff : fi_ff;
      rr_new     = rear_hit ? range_sample : rr_ff;
      ri_new     = rear_hit ? cnt_ff : ri_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         fr_ff   <= '1;
         fi_ff   <= '0;
         rr_ff   <= '1;
         ri_ff   <= '0;
         dfr_ff  <= '1;
         dfi_ff  <= '0;
         drr_ff  <= '1;
         dri_ff  <= '0;
         seen_ff <= 1'b0;
      end else if (cmd.take_sample) begin
         if (scan_end) begin
            dfr_ff  <= fr_new;
            dfi_ff  <= fi_new;
            drr_ff  <= rr_new;
            dri_ff  <= ri_new;
            seen_ff <= 1'b1;
            fr_ff   <= '1;
            fi_ff   <= '0;
            rr_ff   <= '1;
            ri_ff   <= '0;
            cnt_ff  <= '0;
         end else begin
            fr_ff  <= fr_new;
            fi_ff  <= fi_new;
            rr_ff  <= rr_new;
            ri_ff  <= ri_new;
            cnt_ff <= cnt_ff + 12'd1;
         end
      end
   end

   assign status.scan_seen = seen_ff;

   // Tick datapath registers.
   logic [15:0]        d_sel;
   logic [11:0]        idx_sel;
   logic               near_ff;
   logic [31:0]        dsq_ff, rem_ff;
   logic [25:0]        prod_ff;
   logic [27:0]        ang_ff, quo_ff;
   logic signed [19:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic signed [35:0] pc_ff, ps_ff;
   logic signed [15:0] rx_ff, ry_ff, fx_ff;
   logic signed [32:0] vx_ff, vy_ff;
   logic signed [20:0] vz_ff;
   logic               zero_ff;

   // Combinational helpers for each step.
   logic [32:0]        div_shift;
   logic [27:0]        mod_thr;
   logic [14:0]        force_mag;
   logic signed [17:0] fold_r;
   logic               fold_flip;
   logic [3:0]         sh;
   logic signed [19:0] atan_rot;
   logic signed [20:0] atan_vec;
   logic signed [19:0] cos_v, sin_v;
   logic signed [15:0] rx_v, ry_v;
   logic signed [32:0] vx0, vy0;
   logic signed [20:0] turn_full;
   logic signed [17:0] turn_q;
   logic signed [15:0] turn_v;

   always_comb begin
      sh        = cmd.step[3:0];
      d_sel     = (dfr_ff < drr_ff) ? dfr_ff : drr_ff;
      idx_sel   = (dfr_ff < drr_ff) ? dfi_ff : dri_ff;
      div_shift = {rem_ff, quo_ff[27]};
      mod_thr   = TWO_PI_Q13 << (4'd11 - sh);
      force_mag = (quo_ff > {13'd0, flim_ff}) ? flim_ff : quo_ff[14:0];
      atan_rot  = {3'b000, atan_lut(sh)};
      atan_vec  = {4'b0000, atan_lut(sh)};
      // Bring the reduced angle into [-pi/2, pi/2], remembering a half turn.
      fold_r    = {2'b00, ang_ff[15:0]};
      fold_flip = 1'b0;
      if (fold_r >= PI_Q13) fold_r = fold_r - 18'sd51472;
      if (fold_r > HALF_PI_Q13) begin
         fold_r    = fold_r - PI_Q13;
         fold_flip = 1'b1;
      end else if (fold_r < -HALF_PI_Q13) begin
         fold_r    = fold_r + PI_Q13;
         fold_flip = 1'b1;
      end
      cos_v = flip_ff ? -cx_ff : cx_ff;
      sin_v = flip_ff ? -cy_ff : cy_ff;
      rx_v  = near_ff ? sat16(24'(-(pc_ff >>> 16))) : 16'sd0;
      ry_v  = near_ff ? sat16(24'(-(ps_ff >>> 16))) : 16'sd0;
      vx0   = 33'(fx_ff) <<< 14;
      vy0   = 33'(ry_ff) <<< 14;
      turn_full = (vz_ff + 21'sd4) >>> 3;
      if (turn_full > 21'(PI_Q13)) begin
         turn_q = PI_Q13;
      end else if (turn_full < -21'(PI_Q13)) begin
         turn_q = -PI_Q13;
      end else begin
         turn_q = turn_full[17:0];
      end
      turn_v = zero_ff ? 16'sd0 : turn_q[15:0];
   end

   always_ff @(posedge clock) begin
      // Pick the closer latched minimum and start the division and angle product.
      if (cmd.prep) begin
         near_ff <= d_sel < infl_ff;
         dsq_ff  <= d_sel * d_sel;
         prod_ff <= idx_sel * astep_ff;
         rem_ff  <= '0;
         quo_ff  <= {sg_ff, 12'd0};
      end
      // Angle offset by one full turn so the reduction starts non-negative.
      if (cmd.angle) begin
         ang_ff <= {2'b00, prod_ff} + {{12{fa_ff[15]}}, fa_ff} + TWO_PI_Q13;
      end
      // Restoring division, one quotient bit a cycle.
      if (cmd.div_step) begin
         if (div_shift >= {1'b0, dsq_ff}) begin
            rem_ff <= 32'(div_shift - {1'b0, dsq_ff});
            quo_ff <= {quo_ff[26:0], 1'b1};
         end else begin
            rem_ff <= div_shift[31:0];
            quo_ff <= {quo_ff[26:0], 1'b0};
         end
      end
      // Reduction modulo a full turn, one shifted multiple a cycle.
      if (cmd.mod_step && ang_ff >= mod_thr) begin
         ang_ff <= ang_ff - mod_thr;
      end
      if (cmd.rot_init) begin
         cx_ff   <= CORDIC_GAIN;
         cy_ff   <= 20'sd0;
         cz_ff   <= 20'(fold_r) <<< 3;
         flip_ff <= fold_flip;
      end
      // Rotation CORDIC for cosine and sine.
      if (cmd.rot_step) begin
         if (!cz_ff[19]) begin
            cx_ff <= cx_ff - (cy_ff >>> sh);
            cy_ff <= cy_ff + (cx_ff >>> sh);
            cz_ff <= cz_ff - atan_rot;
         end else begin
            cx_ff <= cx_ff + (cy_ff >>> sh);
            cy_ff <= cy_ff - (cx_ff >>> sh);
            cz_ff <= cz_ff + atan_rot;
         end
      end
      if (cmd.mul) begin
         pc_ff <= $signed({1'b0, force_mag}) * cos_v;
         ps_ff <= $signed({1'b0, force_mag}) * sin_v;
      end
      if (cmd.sat) begin
         rx_ff <= rx_v;
         ry_ff <= ry_v;
         fx_ff <= sat16(24'(HALF_Q12 + 17'(rx_v)));
      end
      // Vectoring CORDIC setup: move a left half-plane vector to the right.
      if (cmd.vec_init) begin
         zero_ff <= (fx_ff == 16'sd0) && (ry_ff == 16'sd0);
         if (fx_ff[15]) begin
            vx_ff <= -vx0;
            vy_ff <= -vy0;
            vz_ff <= ry_ff[15] ? -PI_Q16 : PI_Q16;
         end else begin
            vx_ff <= vx0;
            vy_ff <= vy0;
            vz_ff <= 21'sd0;
         end
      end
      if (cmd.vec_step) begin
         if (!vy_ff[32]) begin
            vx_ff <= vx_ff + (vy_ff >>> sh);
            vy_ff <= vy_ff - (vx_ff >>> sh);
            vz_ff <= vz_ff + atan_vec;
         end else begin
            vx_ff <= vx_ff - (vy_ff >>> sh);
            vy_ff <= vy_ff + (vx_ff >>> sh);
            vz_ff <= vz_ff - atan_vec;
         end
      end
      // Result register; all zero before the first complete scan.
      if (cmd.load_out) begin
         if (seen_ff) begin
            linear_velocity <= fx_ff;
            turn_rate       <= turn_v;
            repulse_x       <= rx_ff;
            repulse_y       <= ry_ff;
         end else begin
            linear_velocity <= '0;
            turn_rate       <= '0;
            repulse_x       <= '0;
            repulse_y       <= '0;
         end
      end
   end

endmodule

// ----- hw/rtl/pfas_checker.sv -----
`include "potential_field_avoidance_steer_assert.svh"

module pfas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // A stalled result stays offered.
   `PFAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")

   // A stalled result keeps its payload.
   `PFAS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp changed")

   // A tick transfer makes the block busy in the next cycle.
   `PFAS_ASSERT_NEXT(a_tick_busy, clock, reset, req_tvalid && req_tready && req_tuser[0], !req_tready, "tick not busy")

   // A new result only follows a busy cycle.
   `PFAS_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "rsp out of tick")

endmodule

bind potential_field_avoidance_steer pfas_checker u_pfas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
